@@ hdl/vehicle_lamp_duty_controller_assert.svh @@
// Assertion macros for the lamp duty controller.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef VEHICLE_LAMP_DUTY_CONTROLLER_ASSERT_SVH
`define VEHICLE_LAMP_DUTY_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF

// a holds at an edge -> b holds at the same edge
`define VLDC_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: same-cycle check failed");

// a holds at an edge -> b holds at the next edge
`define VLDC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: next-cycle check failed");

`else

`define VLDC_ASSERT_SAME(label, clk, rst, a, b)
`define VLDC_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

@@ hdl/vldc_pkg.sv @@
// Shared types, codes and constants for the lamp duty controller.
// No dependencies; every other design module imports this package.
package vldc_pkg;

  // envelope and duty scale
  localparam int unsigned FADE_IN_MS  = 50;
  localparam int unsigned FADE_OUT_MS = 100;
  localparam int unsigned FULL_DUTY   = 1000;

  localparam int MS_W    = 16;
  localparam int SDUTY_W = 10;
  localparam int DUTY_W  = 16;
  localparam int RAMP_W  = 10;
  localparam int TURN_W  = 18;
  localparam int FLASH_W = 17;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [MS_W-1:0]    HOLD_RST     = 16'd300;
  localparam logic [MS_W-1:0]    GAP_RST      = 16'd500;
  localparam logic [MS_W-1:0]    BRAKE_ON_RST = 16'd125;
  localparam logic [MS_W-1:0]    BRAKE_OFF_RST = 16'd125;
  localparam logic [SDUTY_W-1:0] DAYTIME_RST  = 10'd100;
  localparam logic [SDUTY_W-1:0] TAIL_RST     = 10'd100;

  // register indexes
  localparam logic [2:0] REG_HOLD      = 3'd0;
  localparam logic [2:0] REG_GAP       = 3'd1;
  localparam logic [2:0] REG_BRAKE_ON  = 3'd2;
  localparam logic [2:0] REG_BRAKE_OFF = 3'd3;
  localparam logic [2:0] REG_DAYTIME   = 3'd4;
  localparam logic [2:0] REG_TAIL      = 3'd5;

  // headlight modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_DAY    = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;

  // turn-signal selects
  localparam logic [1:0] TURN_OFF    = 2'd0;
  localparam logic [1:0] TURN_LEFT   = 2'd1;
  localparam logic [1:0] TURN_RIGHT  = 2'd2;
  localparam logic [1:0] TURN_HAZARD = 2'd3;

  // Ramps are floor(e * FULL_DUTY / D), done as e * (FULL_DUTY * M) >> S with
  // M = ceil(2^S / D); S is large enough that the result is exact.
  localparam int IN_S = $clog2(FADE_IN_MS * FULL_DUTY + 1) + $clog2(FADE_IN_MS) + 1;
  localparam longint unsigned IN_M = ((64'd1 << IN_S) + FADE_IN_MS - 1) / FADE_IN_MS;
  localparam longint unsigned IN_K = IN_M * FULL_DUTY;
  localparam int IN_PW = $clog2(IN_K + 1) + RAMP_W;

  localparam int OUT_S = $clog2(FADE_OUT_MS * FULL_DUTY + 1) + $clog2(FADE_OUT_MS) + 1;
  localparam longint unsigned OUT_M = ((64'd1 << OUT_S) + FADE_OUT_MS - 1) / FADE_OUT_MS;
  localparam longint unsigned OUT_K = OUT_M * FULL_DUTY;
  localparam int OUT_PW = $clog2(OUT_K + 1) + RAMP_W;

  typedef struct packed {
    logic [1:0] beam_mode;
    logic       passing;
    logic       brake_request;
    logic       flash_request;
    logic [1:0] turn_select;
  } vldc_in_t;

  typedef struct packed {
    logic [SDUTY_W-1:0] front_duty;
    logic [SDUTY_W-1:0] rear_duty;
    logic [SDUTY_W-1:0] left_lamp;
    logic [SDUTY_W-1:0] right_lamp;
  } vldc_out_t;

  // settings in the form the datapath uses them
  typedef struct packed {
    logic [TURN_W-1:0]  hold_end;
    logic [TURN_W-1:0]  fade_end;
    logic [TURN_W-1:0]  turn_period;
    logic [MS_W-1:0]    flash_on;
    logic [FLASH_W-1:0] flash_period;
    logic [DUTY_W-1:0]  day_sat;
    logic [DUTY_W-1:0]  tail_sat;
  } vldc_cfg_t;

endpackage

@@ hdl/vldc_cfg_regs.sv @@
// Configuration registers behind the APB-style port, plus the derived
// thresholds and saturated duties handed to the datapath. Uses vldc_pkg.
module vldc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vldc_pkg::PADDR_W-1:0] paddr,
  input  logic [vldc_pkg::PDATA_W-1:0] pwdata,
  output logic [vldc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output vldc_pkg::vldc_cfg_t          cfg
);
  import vldc_pkg::*;

  logic [MS_W-1:0]    hold_ms, gap_ms, brake_on_ms, brake_off_ms;
  logic [SDUTY_W-1:0] daytime_duty, tail_duty;
  logic [MS_W-1:0]    hold_next, gap_next, on_next, off_next;
  logic [SDUTY_W-1:0] day_next, tail_next;
  logic [2:0]         reg_idx;
  logic               wr;
  vldc_cfg_t          cfg_next;
  vldc_cfg_t          cfg_rst;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    hold_next = hold_ms;
    gap_next  = gap_ms;
    on_next   = brake_on_ms;
    off_next  = brake_off_ms;
    day_next  = daytime_duty;
    tail_next = tail_duty;
    if (wr) begin
      case (reg_idx)
        REG_HOLD:      hold_next = pwdata[MS_W-1:0];
        REG_GAP:       gap_next  = pwdata[MS_W-1:0];
        REG_BRAKE_ON:  on_next   = pwdata[MS_W-1:0];
        REG_BRAKE_OFF: off_next  = pwdata[MS_W-1:0];
        REG_DAYTIME:   day_next  = pwdata[SDUTY_W-1:0];
        REG_TAIL:      tail_next = pwdata[SDUTY_W-1:0];
        default:       ;
      endcase
    end
  end

  // derive from the values the registers take at this edge
  always_comb begin
    cfg_next.hold_end     = TURN_W'(FADE_IN_MS) + TURN_W'(hold_next);
    cfg_next.fade_end     = cfg_next.hold_end + TURN_W'(FADE_OUT_MS);
    cfg_next.turn_period  = cfg_next.fade_end + TURN_W'(gap_next);
    cfg_next.flash_on     = on_next;
    cfg_next.flash_period = FLASH_W'(on_next) + FLASH_W'(off_next);
    cfg_next.day_sat      = (DUTY_W'(day_next) > DUTY_W'(FULL_DUTY)) ?
                            DUTY_W'(FULL_DUTY) : DUTY_W'(day_next);
    cfg_next.tail_sat     = (DUTY_W'(tail_next) > DUTY_W'(FULL_DUTY)) ?
                            DUTY_W'(FULL_DUTY) : DUTY_W'(tail_next);
  end

  always_comb begin
    cfg_rst.hold_end     = TURN_W'(FADE_IN_MS) + TURN_W'(HOLD_RST);
    cfg_rst.fade_end     = cfg_rst.hold_end + TURN_W'(FADE_OUT_MS);
    cfg_rst.turn_period  = cfg_rst.fade_end + TURN_W'(GAP_RST);
    cfg_rst.flash_on     = BRAKE_ON_RST;
    cfg_rst.flash_period = FLASH_W'(BRAKE_ON_RST) + FLASH_W'(BRAKE_OFF_RST);
    cfg_rst.day_sat      = (DUTY_W'(DAYTIME_RST) > DUTY_W'(FULL_DUTY)) ?
                           DUTY_W'(FULL_DUTY) : DUTY_W'(DAYTIME_RST);
    cfg_rst.tail_sat     = (DUTY_W'(TAIL_RST) > DUTY_W'(FULL_DUTY)) ?
                           DUTY_W'(FULL_DUTY) : DUTY_W'(TAIL_RST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms      <= HOLD_RST;
      gap_ms       <= GAP_RST;
      brake_on_ms  <= BRAKE_ON_RST;
      brake_off_ms <= BRAKE_OFF_RST;
      daytime_duty <= DAYTIME_RST;
      tail_duty    <= TAIL_RST;
      cfg          <= cfg_rst;
    end else begin
      hold_ms      <= hold_next;
      gap_ms       <= gap_next;
      brake_on_ms  <= on_next;
      brake_off_ms <= off_next;
      daytime_duty <= day_next;
      tail_duty    <= tail_next;
      cfg          <= cfg_next;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD:      prdata = PDATA_W'(hold_ms);
      REG_GAP:       prdata = PDATA_W'(gap_ms);
      REG_BRAKE_ON:  prdata = PDATA_W'(brake_on_ms);
      REG_BRAKE_OFF: prdata = PDATA_W'(brake_off_ms);
      REG_DAYTIME:   prdata = PDATA_W'(daytime_duty);
      REG_TAIL:      prdata = PDATA_W'(tail_duty);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/vldc_envelope.sv @@
// Turn-signal envelope: fade in, hold, fade out, gap, from the wrapped count.
// Uses vldc_pkg for the ramp constants and the settings struct.
module vldc_envelope (
  input  logic [vldc_pkg::TURN_W-1:0] count,
  input  vldc_pkg::vldc_cfg_t         cfg,
  output logic [vldc_pkg::DUTY_W-1:0] duty
);
  import vldc_pkg::*;

  logic [TURN_W-1:0] out_pos;
  logic [RAMP_W-1:0] up_e, down_e;
  logic [IN_PW-1:0]  up_prod;
  logic [OUT_PW-1:0] down_prod;

  assign out_pos = count - cfg.hold_end;
  assign up_e    = count[RAMP_W-1:0];
  assign down_e  = RAMP_W'(FADE_OUT_MS) - out_pos[RAMP_W-1:0];

  // constant multiply by the scaled reciprocal, then drop the fraction
  assign up_prod   = IN_PW'(up_e) * IN_PW'(IN_K);
  assign down_prod = OUT_PW'(down_e) * OUT_PW'(OUT_K);

  always_comb begin
    if (count < TURN_W'(FADE_IN_MS)) begin
      duty = DUTY_W'(up_prod >> IN_S);
    end else if (count < cfg.hold_end) begin
      duty = DUTY_W'(FULL_DUTY);
    end else if (count < cfg.fade_end) begin
      duty = DUTY_W'(down_prod >> OUT_S);
    end else begin
      duty = '0;
    end
  end

endmodule

@@ hdl/vehicle_lamp_duty_controller.sv @@
// Vehicle lamp duty controller top level: input register, lamp logic, result.
// Uses vldc_pkg, vldc_cfg_regs, vldc_envelope and the assertion header.
`include "vehicle_lamp_duty_controller_assert.svh"

// Each input word is one millisecond tick; each accepted word yields exactly
// one result word of front, rear, left and right duties in per mille. One
// word is taken per clock cycle while the output does not stall: a word is
// held in the input register, and the lamp logic and counter updates are
// combinational from there into the result register. While a result waits
// to be taken, the input register can still take one more word; after that
// the input stalls until the result leaves. The user must write settings
// via the APB-style port while no words are in flight; the block does not
// enforce it. They take effect from the next word. No clearing after reset.
module vehicle_lamp_duty_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vldc_pkg::vldc_in_t           in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vldc_pkg::vldc_out_t          out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vldc_pkg::PADDR_W-1:0] paddr,
  input  logic [vldc_pkg::PDATA_W-1:0] pwdata,
  output logic [vldc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import vldc_pkg::*;

  vldc_cfg_t          cfg;
  logic               s1_valid;
  vldc_in_t           s1_word;
  logic               s1_fire;

  logic [1:0]         stored_turn;
  logic [TURN_W-1:0]  turn_count;
  logic               was_flashing;
  logic [FLASH_W-1:0] flash_count;

  logic               flashing;
  logic               turn_change;
  logic [TURN_W-1:0]  tc_base, tc_use, turn_count_next;
  logic [FLASH_W-1:0] fc_base, fc_use;
  logic [DUTY_W-1:0]  tail, front, rear, env, left, right;
  vldc_out_t          out_next;

  vldc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vldc_envelope u_env (
    .count (tc_use),
    .cfg   (cfg),
    .duty  (env)
  );

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // brake flashing
  assign flashing = s1_word.brake_request && s1_word.flash_request;
  assign fc_base  = (flashing && !was_flashing) ? '0 : flash_count;
  assign fc_use   = (fc_base >= cfg.flash_period) ? '0 : fc_base;
  assign tail     = (s1_word.beam_mode != MODE_OFF) ? cfg.tail_sat : '0;

  always_comb begin
    if (!s1_word.brake_request) begin
      rear = tail;
    end else if (!flashing) begin
      rear = DUTY_W'(FULL_DUTY);
    end else if (FLASH_W'(cfg.flash_on) > fc_use) begin
      rear = DUTY_W'(FULL_DUTY);
    end else begin
      rear = tail;
    end
  end

  always_comb begin
    if (s1_word.passing || s1_word.beam_mode >= MODE_NORMAL) begin
      front = DUTY_W'(FULL_DUTY);
    end else if (s1_word.beam_mode == MODE_DAY) begin
      front = cfg.day_sat;
    end else begin
      front = '0;
    end
  end

  // turn signal: a new select restarts the envelope
  assign turn_change = s1_word.turn_select != stored_turn;
  assign tc_base     = turn_change ? '0 : turn_count;
  assign tc_use      = (tc_base >= cfg.turn_period) ? '0 : tc_base;

  always_comb begin
    left            = '0;
    right           = '0;
    turn_count_next = tc_base;
    if (s1_word.turn_select != TURN_OFF) begin
      turn_count_next = tc_use + TURN_W'(1);
      if (s1_word.turn_select == TURN_LEFT || s1_word.turn_select == TURN_HAZARD) begin
        left = env;
      end
      if (s1_word.turn_select == TURN_RIGHT || s1_word.turn_select == TURN_HAZARD) begin
        right = env;
      end
    end
  end

  always_comb begin
    out_next.front_duty = front[SDUTY_W-1:0];
    out_next.rear_duty  = rear[SDUTY_W-1:0];
    out_next.left_lamp  = left[SDUTY_W-1:0];
    out_next.right_lamp = right[SDUTY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      stored_turn  <= TURN_OFF;
      turn_count   <= '0;
      was_flashing <= 1'b0;
      flash_count  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid    <= 1'b1;
        stored_turn  <= s1_word.turn_select;
        turn_count   <= turn_count_next;
        was_flashing <= flashing;
        if (flashing) begin
          flash_count <= fc_use + FLASH_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on acceptance, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_word;
    end
    if (s1_fire) begin
      out_word <= out_next;
    end
  end

  // a processed word always lands in the result register
  `VLDC_ASSERT_NEXT(a_result_loaded, clk, rst, s1_fire, out_valid)
  // a held word stays put until it moves on
  `VLDC_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_fire, s1_valid && $stable(s1_word))
  // turn lamps are either one-sided or equal (hazard)
  `VLDC_ASSERT_SAME(a_turn_sides, clk, rst, out_valid,
                    out_word.left_lamp == '0 || out_word.right_lamp == '0 ||
                    out_word.left_lamp == out_word.right_lamp)
  // no result without a word behind it
  `VLDC_ASSERT_NEXT(a_no_phantom, clk, rst, !out_valid && !s1_fire, !out_valid)

endmodule
